FILE: rtl/gra_pkg.sv
`timescale 1ns / 1ps

package gra_pkg;

  // Field widths of the channels
  localparam int RAW_W       = 16;
  localparam int STOP_W      = 16;
  localparam int RATE_OUT_W  = 32;
  localparam int ANGLE_W     = 19;
  localparam int BIAS_OUT_W  = 32;

  // Configuration registers
  localparam int SCALE_W     = 18;
  localparam int STEP_W      = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [SCALE_W-1:0] RATE_SCALE_RST  = 18'd65536;
  localparam logic [STEP_W-1:0]  STEP_TIME_RST   = 24'd167772;
  localparam logic [STOP_W-1:0]  STOP_THRESH_RST = 16'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE_SCALE  = 2'd0,
    CFG_STEP_TIME   = 2'd1,
    CFG_STOP_THRESH = 2'd2
  } cfg_idx_t;

  // Internal value ranges (window mean never exceeds 2^19 in magnitude)
  localparam int MEAN_MAG_W  = 19;
  localparam int MEAN_W      = 20;
  localparam int DIFF_MAG_W  = 20;
  localparam int RATE_MAG_W  = 23;
  localparam int RATE_W      = 24;
  localparam int WRAP_W      = 25;

  // Scaling constants
  localparam int COEF_W      = 27;
  localparam logic [COEF_W-1:0] DEG2RAD_Q32 = 27'd74961321;
  localparam int LSB_PER_DPS = 131;
  localparam int Q16_ONE     = 65536;
  localparam int RATE_FRAC   = 16;
  localparam int STEP_FRAC   = 24;
  localparam int PI_Q16      = 205887;
  localparam int TWO_PI_Q16  = 411775;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_MMUL,
    ST_DIVLD,
    ST_DIV,
    ST_BIAS,
    ST_RMUL,
    ST_RRND,
    ST_AMUL,
    ST_ARND,
    ST_WRAP
  } state_t;

endpackage

FILE: rtl/gra_ifs.sv
`timescale 1ns / 1ps

// Input sample channel
interface gra_in_if
  import gra_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [RAW_W-1:0]  raw_rate;
  logic [STOP_W-1:0]        motors_stopped_ms;

  modport source (output valid, output raw_rate, output motors_stopped_ms, input ready);
  modport sink   (input valid, input raw_rate, input motors_stopped_ms, output ready);
endinterface

// Result channel
interface gra_out_if
  import gra_pkg::*;
  ();
  logic                          valid;
  logic                          ready;
  logic signed [RATE_OUT_W-1:0]  rate_rad;
  logic signed [ANGLE_W-1:0]     angle_rad;
  logic signed [BIAS_OUT_W-1:0]  bias_rad;

  modport source (output valid, output rate_rad, output angle_rad, output bias_rad,
                  input ready);
  modport sink   (input valid, input rate_rad, input angle_rad, input bias_rad,
                  output ready);
endinterface

// Register write channel
interface gra_cfg_if
  import gra_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   idx;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

FILE: rtl/gyro_rate_average_integrator.sv
// Gyro z-rate averager, bias remover and angle integrator.
//
// in_ch carries one raw z sample (131 LSB per deg/s) and the motors-stopped
// time per transaction; out_ch returns rate, wrapped angle and bias, all Q16.
// cfg_ch writes rate_scale (0), step_time (1) and stop_threshold_ms (2); it
// is always ready and other indexes are dropped.
//
// One shared multiplier runs under a sequencer, one item at a time. The mean
// divide by 131 * WINDOW_LEN * 65536 is a shift and a reciprocal multiply.
// From acceptance, the result is loaded after these steps: window update,
// mean multiply, shift, reciprocal multiply, bias, gain multiply, rounding,
// step multiply, rounding, and wrap steps that add or subtract 2*pi until the
// angle lies in [-pi, pi). in_ch.ready rises together with out_ch.valid.
//
// The result sits in an output register, so a new item is accepted while it
// waits. If the receiver still holds the previous result when the next one is
// done, the sequencer waits in its last step until out_ch frees up.
// Reset (rst_n low, synchronous) empties the sample window, zeroes bias and
// angle, loads the register defaults and drops any pending result.
`timescale 1ns / 1ps

module gyro_rate_average_integrator
  import gra_pkg::*;
#(
  parameter int WINDOW_LEN = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  gra_in_if.sink     in_ch,
  gra_out_if.source  out_ch,
  gra_cfg_if.sink    cfg_ch
);

  localparam int PTR_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SUM_W     = 17 + $clog2(WINDOW_LEN);
  localparam int SUM_MAG_W = SUM_W - 1;

  // Mean divisor split into 2^16 and 131 * WINDOW_LEN; the second part is a
  // reciprocal multiply that is exact for every quotient below 2^MEAN_MAG_W
  localparam longint DIVQ   = longint'(LSB_PER_DPS) * WINDOW_LEN;
  localparam int     Q16_SH = $clog2(Q16_ONE);
  localparam int     DQ_W   = $clog2(DIVQ);
  localparam int     T_W    = MEAN_MAG_W + DQ_W;
  localparam int     RCP_SH = T_W + DQ_W;
  localparam int     RCP_W  = T_W + 1;
  localparam longint RCP    = ((longint'(1) << RCP_SH) + DIVQ - 1) / DIVQ;

  localparam int MUL_A0_W  = (SUM_MAG_W > RATE_MAG_W) ? SUM_MAG_W : RATE_MAG_W;
  localparam int MUL_A_W   = (T_W > MUL_A0_W) ? T_W : MUL_A0_W;
  localparam int MUL_B_W   = (RCP_W > COEF_W) ? RCP_W : COEF_W;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  localparam logic [PROD_W-1:0]  DIV_HALF = PROD_W'(DIVQ << (Q16_SH - 1));
  localparam logic [MUL_B_W-1:0] RCP_C    = MUL_B_W'(RCP);

  localparam logic [PROD_W-1:0] RND_RATE = PROD_W'(64'd1 << (RATE_FRAC - 1));
  localparam logic [PROD_W-1:0] RND_STEP = PROD_W'(64'd1 << (STEP_FRAC - 1));

  localparam logic signed [WRAP_W-1:0] PI_W     = WRAP_W'(PI_Q16);
  localparam logic signed [WRAP_W-1:0] TWO_PI_W = WRAP_W'(TWO_PI_Q16);

  // Sequencer and configuration
  state_t                     state_r, state_nxt;
  logic [SCALE_W-1:0]         scale_r;
  logic [STEP_W-1:0]          step_r;
  logic [STOP_W-1:0]          thr_r;

  // Window storage
  logic signed [RAW_W-1:0]    win_mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0]      vld_r;
  logic [PTR_W-1:0]           ptr_r;
  logic signed [RAW_W-1:0]    old_r;
  logic signed [SUM_W-1:0]    sum_r;

  // Working registers
  logic signed [RAW_W-1:0]    raw_r;
  logic [STOP_W-1:0]          stop_r;
  logic [MUL_A_W-1:0]         mag_r;
  logic                       neg_r;
  logic [PROD_W-1:0]          prod_r;
  logic signed [MEAN_W-1:0]   bias_r;
  logic signed [ANGLE_W-1:0]  angle_r;
  logic signed [WRAP_W-1:0]   wrap_r;
  logic signed [RATE_W-1:0]   rate_r;

  // Output register
  logic                          out_valid_r;
  logic signed [RATE_OUT_W-1:0]  out_rate_r;
  logic signed [ANGLE_W-1:0]     out_angle_r;
  logic signed [BIAS_OUT_W-1:0]  out_bias_r;

  // Combinational datapath
  logic                       in_acc;
  logic                       in_ready;
  logic                       out_free;
  logic                       wrap_done;
  logic [MUL_B_W-1:0]         mul_b;
  logic [PROD_W-1:0]          mul_p;
  logic signed [RAW_W-1:0]    old_eff;
  logic signed [SUM_W-1:0]    sum_upd;
  logic [SUM_W-1:0]           sum_abs;
  logic [PROD_W-1:0]          rnd_mean;
  logic [MEAN_MAG_W-1:0]      q_mean;
  logic signed [MEAN_W-1:0]   mean_s;
  logic signed [MEAN_W-1:0]   bias_upd;
  logic signed [MEAN_W:0]     diff_s;
  logic [MEAN_W:0]            diff_abs;
  logic [PROD_W-1:0]          rnd_rate;
  logic [RATE_MAG_W-1:0]      rate_mag;
  logic [PROD_W-1:0]          rnd_step;
  logic [RATE_MAG_W-1:0]      step_mag;
  logic signed [WRAP_W-1:0]   step_s;
  logic signed [WRAP_W-1:0]   wrap_ld;
  logic signed [WRAP_W-1:0]   angle_fin;

  assign in_acc    = in_ch.valid && in_ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign wrap_done = (wrap_r >= 0) && (wrap_r < TWO_PI_W);

  // Window sum update and its magnitude
  assign old_eff  = vld_r[ptr_r] ? old_r : '0;
  assign sum_upd  = sum_r + SUM_W'(raw_r) - SUM_W'(old_eff);
  assign sum_abs  = sum_upd[SUM_W-1] ? SUM_W'(-sum_upd) : SUM_W'(sum_upd);

  // Shared multiplier
  assign mul_p = PROD_W'(mag_r) * PROD_W'(mul_b);

  // Mean division: add half the divisor, drop 16 bits, reciprocal multiply
  assign rnd_mean = prod_r + DIV_HALF;
  assign q_mean   = prod_r[RCP_SH +: MEAN_MAG_W];

  // Mean, bias capture and corrected difference
  assign mean_s   = neg_r ? -$signed({1'b0, q_mean}) : $signed({1'b0, q_mean});
  assign bias_upd = (stop_r > thr_r) ? mean_s : bias_r;
  assign diff_s   = (MEAN_W+1)'(mean_s) - (MEAN_W+1)'(bias_upd);
  assign diff_abs = diff_s[MEAN_W] ? (MEAN_W+1)'(-diff_s) : (MEAN_W+1)'(diff_s);

  // Rounding of the gain product and the angle step, ties away from zero
  assign rnd_rate = prod_r + RND_RATE;
  assign rate_mag = rnd_rate[RATE_FRAC +: RATE_MAG_W];
  assign rnd_step = prod_r + RND_STEP;
  assign step_mag = rnd_step[STEP_FRAC +: RATE_MAG_W];
  assign step_s   = neg_r ? -$signed(WRAP_W'(step_mag)) : $signed(WRAP_W'(step_mag));
  assign wrap_ld  = WRAP_W'(angle_r) + PI_W - step_s;
  assign angle_fin = wrap_r - PI_W;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_MMUL;
      ST_MMUL:  state_nxt = ST_DIVLD;
      ST_DIVLD: state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_BIAS;
      ST_BIAS:  state_nxt = ST_RMUL;
      ST_RMUL:  state_nxt = ST_RRND;
      ST_RRND:  state_nxt = ST_AMUL;
      ST_AMUL:  state_nxt = ST_ARND;
      ST_ARND:  state_nxt = ST_WRAP;
      ST_WRAP:  if (wrap_done && out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    mul_b    = MUL_B_W'(DEG2RAD_Q32);
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_MMUL: mul_b = MUL_B_W'(DEG2RAD_Q32);
      ST_DIV:  mul_b = RCP_C;
      ST_RMUL: mul_b = MUL_B_W'(scale_r);
      ST_AMUL: mul_b = MUL_B_W'(step_r);
      default: ;
    endcase
  end

  // Window memory: read at acceptance, written once the sum is updated
  always_ff @(posedge clk) begin
    if (in_acc) old_r <= win_mem[ptr_r];
    if (state_r == ST_SUM) win_mem[ptr_r] <= raw_r;
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scale_r     <= RATE_SCALE_RST;
      step_r      <= STEP_TIME_RST;
      thr_r       <= STOP_THRESH_RST;
      vld_r       <= '0;
      ptr_r       <= '0;
      sum_r       <= '0;
      bias_r      <= '0;
      angle_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_ch.valid) begin
        case (cfg_idx_t'(cfg_ch.idx))
          CFG_RATE_SCALE:  scale_r <= cfg_ch.data[SCALE_W-1:0];
          CFG_STEP_TIME:   step_r  <= cfg_ch.data[STEP_W-1:0];
          CFG_STOP_THRESH: thr_r   <= cfg_ch.data[STOP_W-1:0];
          default: ;
        endcase
      end

      if (state_r == ST_SUM) begin
        sum_r        <= sum_upd;
        vld_r[ptr_r] <= 1'b1;
        ptr_r        <= (ptr_r == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_r + 1'b1;
      end

      if (state_r == ST_BIAS) bias_r <= bias_upd;

      // Result load and hand-off
      if (state_r == ST_WRAP && wrap_done && out_free) begin
        angle_r     <= angle_fin[ANGLE_W-1:0];
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      raw_r  <= in_ch.raw_rate;
      stop_r <= in_ch.motors_stopped_ms;
    end

    case (state_r)
      ST_SUM: begin
        mag_r <= MUL_A_W'(sum_abs[SUM_MAG_W-1:0]);
        neg_r <= sum_upd[SUM_W-1];
      end
      ST_MMUL, ST_DIV, ST_RMUL, ST_AMUL: prod_r <= mul_p;
      ST_DIVLD: mag_r <= MUL_A_W'(rnd_mean[Q16_SH +: T_W]);
      ST_BIAS: begin
        mag_r <= MUL_A_W'(diff_abs[DIFF_MAG_W-1:0]);
        neg_r <= diff_s[MEAN_W];
      end
      ST_RRND: begin
        rate_r <= neg_r ? -$signed(RATE_W'(rate_mag)) : $signed(RATE_W'(rate_mag));
        mag_r  <= MUL_A_W'(rate_mag);
      end
      ST_ARND: wrap_r <= wrap_ld;
      ST_WRAP: begin
        if (wrap_r < 0) begin
          wrap_r <= wrap_r + TWO_PI_W;
        end else if (wrap_r >= TWO_PI_W) begin
          wrap_r <= wrap_r - TWO_PI_W;
        end
      end
      default: ;
    endcase

    if (state_r == ST_WRAP && wrap_done && out_free) begin
      out_rate_r  <= {{(RATE_OUT_W-RATE_W){rate_r[RATE_W-1]}}, rate_r};
      out_angle_r <= angle_fin[ANGLE_W-1:0];
      out_bias_r  <= {{(BIAS_OUT_W-MEAN_W){bias_r[MEAN_W-1]}}, bias_r};
    end
  end

  // Channel drive
  assign in_ch.ready      = in_ready;
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.rate_rad  = out_rate_r;
  assign out_ch.angle_rad = out_angle_r;
  assign out_ch.bias_rad  = out_bias_r;

endmodule

FILE: rtl/gra_checker.sv
`timescale 1ns / 1ps

module gra_checker
  import gra_pkg::*;
(
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [RATE_OUT_W-1:0]  out_rate,
  input logic signed [ANGLE_W-1:0]     out_angle,
  input logic signed [BIAS_OUT_W-1:0]  out_bias
);

  localparam logic signed [ANGLE_W-1:0] PI_A = ANGLE_W'(PI_Q16);

  // One item at a time: the block is busy right after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous item still in work");

  // Reset drops any pending result
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Reported angle always lies in [-pi, pi]
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle >= -PI_A) && (out_angle <= PI_A))
    else $error("angle outside wrap range");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_rate) && $stable(out_angle) && $stable(out_bias))
    else $error("stalled result changed");

endmodule

bind gyro_rate_average_integrator gra_checker u_gra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_rate  (out_ch.rate_rad),
  .out_angle (out_ch.angle_rad),
  .out_bias  (out_ch.bias_rad)
);
